FILE: hdl/ctpd_pkg.sv
// ----------------------------------------------------------------------------
// ctpd_pkg
// Types and constants for the computed-torque PD joint controller.
// ----------------------------------------------------------------------------
package ctpd_pkg;

    localparam int MAX_JOINTS = 7;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int JOINT_W    = 3;
    localparam int TYPE_W     = 2;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [TYPE_W-1:0] {
        REQ_TARGET = 2'd0,
        REQ_MEAS   = 2'd1,
        REQ_ROW    = 2'd2
    } req_type_t;

    typedef struct packed {
        logic [TYPE_W-1:0]         req_type;
        logic [JOINT_W-1:0]        joint;
        logic signed [DATA_W-1:0]  position;
        logic signed [DATA_W-1:0]  velocity;
        logic signed [DATA_W-1:0]  mass_col_zero;
        logic signed [DATA_W-1:0]  mass_col_one;
        logic signed [DATA_W-1:0]  mass_col_two;
        logic signed [DATA_W-1:0]  mass_col_three;
        logic signed [DATA_W-1:0]  mass_col_four;
        logic signed [DATA_W-1:0]  mass_col_five;
        logic signed [DATA_W-1:0]  mass_col_six;
        logic signed [DATA_W-1:0]  coriolis_term;
    } in_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0]        torque_joint;
        logic signed [DATA_W-1:0]  torque;
        logic                      last_joint;
        logic                      saturated;
    } out_item_t;

endpackage

FILE: hdl/computed_torque_pd_joint_control_top.sv
// ----------------------------------------------------------------------------
// computed_torque_pd_joint_control_top
// Computed-torque PD control: per-joint targets, PD acceleration command and
// mass-row torque with Coriolis term, Q16.16 data and Q8.8 gains, saturating.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_data (ctpd_pkg::in_item_t)
//   m_        out        m_valid/m_ready    m_data (ctpd_pkg::out_item_t)
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (gains)
//
// One transaction is accepted per cycle while the output is not stalled; a row
// item passes the input, gain multiply, mass-row lane, partial sum and result
// registers in that order before m_valid rises. Targets are written from the
// input register and accelerations from the gain multiply register.
// All stages advance together and hold while the result register is full and
// m_ready is low. Reset clears gains, targets, accelerations and clip flags.
// ----------------------------------------------------------------------------
module computed_torque_pd_joint_control_top #(
    parameter int JOINTS = ctpd_pkg::MAX_JOINTS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ctpd_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ctpd_pkg::out_item_t                  m_data,
    input  logic                                 cfg_wr_en,
    input  logic [ctpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctpd_pkg::DATA_W-1:0]          cfg_wdata
);
    import ctpd_pkg::*;

    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FLR_W  = ACC_W - 8;
    localparam int LANE_W = 2 * DATA_W;
    localparam int SUM_W  = LANE_W + $clog2(JOINTS + 1) + 1;
    localparam int TQ_W   = SUM_W - 16;

    // configuration and state
    logic [DATA_W-1:0]        gains_reg [MAX_JOINTS];
    logic signed [DATA_W-1:0] tpos_reg  [MAX_JOINTS];
    logic signed [DATA_W-1:0] tvel_reg  [MAX_JOINTS];
    logic signed [DATA_W-1:0] accel_reg [MAX_JOINTS];
    logic [MAX_JOINTS-1:0]    aclip_reg;

    logic adv;

    // input stage
    logic     in_v_reg, in_v_next;
    in_item_t in_reg;

    // gain multiply stage
    logic                      mul_v_reg;
    logic [TYPE_W-1:0]         mul_type_reg;
    logic [JOINT_W-1:0]        mul_joint_reg;
    logic signed [PROD_W-1:0]  kp_prod_reg, kp_prod_next;
    logic signed [PROD_W-1:0]  kd_prod_reg, kd_prod_next;
    logic signed [DATA_W-1:0]  mass_reg [MAX_JOINTS];
    logic signed [DATA_W-1:0]  mass_next [MAX_JOINTS];
    logic signed [DATA_W-1:0]  mul_cor_reg;

    // mass-row lane stage
    logic                      lane_v_reg;
    logic [JOINT_W-1:0]        lane_joint_reg;
    logic signed [LANE_W-1:0]  lane_prod_reg [MAX_JOINTS];
    logic signed [LANE_W-1:0]  lane_prod_next [MAX_JOINTS];
    logic signed [DATA_W-1:0]  lane_cor_reg;
    logic                      lane_clip_reg, lane_clip_next;

    // partial sum stage
    logic                      sum_v_reg;
    logic [JOINT_W-1:0]        sum_joint_reg;
    logic signed [SUM_W-1:0]   sum_even_reg, sum_even_next;
    logic signed [SUM_W-1:0]   sum_odd_reg, sum_odd_next;
    logic                      sum_clip_reg;

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg, m_data_next;

    // combinational helpers
    logic signed [DIFF_W-1:0] diff_pos, diff_vel;
    logic signed [GAIN_W:0]   kp_s, kd_s;
    logic [DATA_W-1:0]        gain_sel;
    logic signed [DATA_W-1:0] tpos_sel, tvel_sel;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [FLR_W-1:0]  acc_flr;
    logic                     acc_ovf;
    logic signed [DATA_W-1:0] accel_sat;
    logic signed [SUM_W-1:0]  total;
    logic signed [TQ_W-1:0]   tq_flr;
    logic                     tq_ovf;

    logic wr_target, wr_accel;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // drop out-of-range joints and the unused request code at the door
    assign in_v_next = s_valid
        && (s_data.joint < JOINT_W'(JOINTS))
        && (s_data.req_type == REQ_TARGET || s_data.req_type == REQ_MEAS
            || s_data.req_type == REQ_ROW);

    // gain multiply: targets are read and written in this stage
    assign gain_sel = gains_reg[in_reg.joint];
    assign tpos_sel = tpos_reg[in_reg.joint];
    assign tvel_sel = tvel_reg[in_reg.joint];
    assign kp_s     = {1'b0, gain_sel[DATA_W-1:GAIN_W]};
    assign kd_s     = {1'b0, gain_sel[GAIN_W-1:0]};
    assign diff_pos = {tpos_sel[DATA_W-1], tpos_sel}
                    - {in_reg.position[DATA_W-1], in_reg.position};
    assign diff_vel = {tvel_sel[DATA_W-1], tvel_sel}
                    - {in_reg.velocity[DATA_W-1], in_reg.velocity};
    assign kp_prod_next = diff_pos * kp_s;
    assign kd_prod_next = diff_vel * kd_s;
    assign wr_target = adv && in_v_reg && (in_reg.req_type == REQ_TARGET);

    always_comb begin
        mass_next[0] = in_reg.mass_col_zero;
        mass_next[1] = in_reg.mass_col_one;
        mass_next[2] = in_reg.mass_col_two;
        mass_next[3] = in_reg.mass_col_three;
        mass_next[4] = in_reg.mass_col_four;
        mass_next[5] = in_reg.mass_col_five;
        mass_next[6] = in_reg.mass_col_six;
    end

    // acceleration: floor by 2^8, then clip to 32 bits
    assign acc_sum   = {kp_prod_reg[PROD_W-1], kp_prod_reg}
                     + {kd_prod_reg[PROD_W-1], kd_prod_reg};
    assign acc_flr   = acc_sum[ACC_W-1:8];
    assign acc_ovf   = !(&acc_flr[FLR_W-1:DATA_W-1]) && (|acc_flr[FLR_W-1:DATA_W-1]);
    assign accel_sat = acc_ovf ? (acc_flr[FLR_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                   : {1'b0, {(DATA_W-1){1'b1}}})
                               : acc_flr[DATA_W-1:0];
    assign wr_accel  = adv && mul_v_reg && (mul_type_reg == REQ_MEAS);

    // mass-row lanes read accelerations in the same stage that writes them
    always_comb begin
        lane_clip_next = 1'b0;
        for (int k = 0; k < MAX_JOINTS; k++) begin
            lane_prod_next[k] = mass_reg[k] * accel_reg[k];
            if (k < JOINTS) begin
                lane_clip_next = lane_clip_next | aclip_reg[k];
            end
        end
    end

    // split the lane sum in two; fold Coriolis in above the fraction bits
    always_comb begin
        sum_even_next = '0;
        sum_odd_next  = SUM_W'(lane_cor_reg) <<< 16;
        for (int k = 0; k < MAX_JOINTS; k++) begin
            if (k < JOINTS) begin
                if (k % 2 == 0) begin
                    sum_even_next = sum_even_next + SUM_W'(lane_prod_reg[k]);
                end else begin
                    sum_odd_next = sum_odd_next + SUM_W'(lane_prod_reg[k]);
                end
            end
        end
    end

    assign total  = sum_even_reg + sum_odd_reg;
    assign tq_flr = total[SUM_W-1:16];
    assign tq_ovf = !(&tq_flr[TQ_W-1:DATA_W-1]) && (|tq_flr[TQ_W-1:DATA_W-1]);

    always_comb begin
        m_data_next.torque_joint = sum_joint_reg;
        m_data_next.last_joint   = (sum_joint_reg == JOINT_W'(JOINTS - 1));
        m_data_next.saturated    = sum_clip_reg || tq_ovf;
        if (tq_ovf) begin
            m_data_next.torque = tq_flr[TQ_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            m_data_next.torque = tq_flr[DATA_W-1:0];
        end
    end

    // control state, gains and per-joint state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg    <= 1'b0;
            mul_v_reg   <= 1'b0;
            lane_v_reg  <= 1'b0;
            sum_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            aclip_reg   <= '0;
            for (int k = 0; k < MAX_JOINTS; k++) begin
                gains_reg[k] <= '0;
                tpos_reg[k]  <= '0;
                tvel_reg[k]  <= '0;
                accel_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en && (cfg_index < CFG_IDX_W'(MAX_JOINTS))) begin
                gains_reg[cfg_index] <= cfg_wdata;
            end
            if (adv) begin
                in_v_reg    <= s_valid && in_v_next;
                mul_v_reg   <= in_v_reg;
                lane_v_reg  <= mul_v_reg && (mul_type_reg == REQ_ROW);
                sum_v_reg   <= lane_v_reg;
                m_valid_reg <= sum_v_reg;
            end
            if (wr_target) begin
                tpos_reg[in_reg.joint] <= in_reg.position;
                tvel_reg[in_reg.joint] <= in_reg.velocity;
            end
            if (wr_accel) begin
                accel_reg[mul_joint_reg] <= accel_sat;
                aclip_reg[mul_joint_reg] <= acc_ovf;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg         <= s_data;
            mul_type_reg   <= in_reg.req_type;
            mul_joint_reg  <= in_reg.joint;
            kp_prod_reg    <= kp_prod_next;
            kd_prod_reg    <= kd_prod_next;
            mul_cor_reg    <= in_reg.coriolis_term;
            lane_joint_reg <= mul_joint_reg;
            lane_cor_reg   <= mul_cor_reg;
            lane_clip_reg  <= lane_clip_next;
            sum_joint_reg  <= lane_joint_reg;
            sum_even_reg   <= sum_even_next;
            sum_odd_reg    <= sum_odd_next;
            sum_clip_reg   <= lane_clip_reg;
            m_data_reg     <= m_data_next;
            for (int k = 0; k < MAX_JOINTS; k++) begin
                mass_reg[k]      <= mass_next[k];
                lane_prod_reg[k] <= lane_prod_next[k];
            end
        end
    end

    // a result always names a joint in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.torque_joint < JOINT_W'(JOINTS)))
        else $error("torque result for joint out of range");

    // last flag marks exactly the final joint
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_joint == (m_data.torque_joint == JOINT_W'(JOINTS - 1))))
        else $error("last_joint does not match joint index");

    // a measurement leaving the multiply stage lands in the acceleration store
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_accel |=> (accel_reg[$past(mul_joint_reg)] == $past(accel_sat)))
        else $error("commanded acceleration not stored");

    // only row items move on to the mass-row lanes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && mul_v_reg && (mul_type_reg != REQ_ROW)) |=> !lane_v_reg)
        else $error("non-row item entered the lane stage");

endmodule
